FILE: rtl/rrbc_pkg.sv
// ----------------------------------------------------------------------------
// rrbc_pkg: shared definitions for the RR-interval beat classifier
// Class codes, register indexes, reset limits and the limit bundle type.
// ----------------------------------------------------------------------------
package rrbc_pkg;

  localparam int POSITION_BITS_DEF = 32;
  localparam int POS_IN_BITS       = 32;
  localparam int LIMIT_BITS        = 16;
  localparam int CFG_IDX_BITS      = 2;
  localparam int CLASS_BITS        = 2;
  localparam int OUT_TDATA_BITS    = 8;

  // Beat class codes.
  localparam logic [CLASS_BITS-1:0] CLASS_INSUFFICIENT = 2'd0;
  localparam logic [CLASS_BITS-1:0] CLASS_NORMAL       = 2'd1;
  localparam logic [CLASS_BITS-1:0] CLASS_ATRIAL       = 2'd2;
  localparam logic [CLASS_BITS-1:0] CLASS_VENTRICULAR  = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_BITS-1:0] REG_DIFF_LIMIT  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_LONG_LIMIT  = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_SHORT_LIMIT = 2'd2;

  localparam logic [LIMIT_BITS-1:0] DIFF_LIMIT_RST  = 16'd40;
  localparam logic [LIMIT_BITS-1:0] LONG_LIMIT_RST  = 16'd150;
  localparam logic [LIMIT_BITS-1:0] SHORT_LIMIT_RST = 16'd120;

  typedef struct packed {
    logic [LIMIT_BITS-1:0] diff_limit;
    logic [LIMIT_BITS-1:0] long_limit;
    logic [LIMIT_BITS-1:0] short_limit;
  } rrbc_limits_t;

endpackage

FILE: rtl/rrbc_history.sv
// ----------------------------------------------------------------------------
// rrbc_history: four-deep QRS position history
// Masks each accepted position, optionally clears, then shifts it in.
// ----------------------------------------------------------------------------
module rrbc_history #(
  parameter int POS_BITS = rrbc_pkg::POSITION_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              load,
  input  logic                              clear_history,
  input  logic [rrbc_pkg::POS_IN_BITS-1:0]  position,
  output logic [3:0][POS_BITS-1:0]          hist
);
  import rrbc_pkg::*;

  logic [3:0][POS_BITS-1:0] hist_r;
  logic [3:0][POS_BITS-1:0] hist_nxt;
  logic [63:0]              pos_wide;
  logic [POS_BITS-1:0]      pos_masked;

  assign pos_wide   = {{(64-POS_IN_BITS){1'b0}}, position};
  assign pos_masked = pos_wide[POS_BITS-1:0];

  // Entry 0 is the oldest position, entry 3 the newest.
  always_comb begin
    hist_nxt = hist_r;
    if (load) begin
      if (clear_history) begin
        hist_nxt[0] = '0;
        hist_nxt[1] = '0;
        hist_nxt[2] = '0;
      end else begin
        hist_nxt[0] = hist_r[1];
        hist_nxt[1] = hist_r[2];
        hist_nxt[2] = hist_r[3];
      end
      hist_nxt[3] = pos_masked;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_r <= '0;
    end else begin
      hist_r <= hist_nxt;
    end
  end

  assign hist = hist_r;

endmodule

FILE: rtl/rrbc_classify.sv
// ----------------------------------------------------------------------------
// rrbc_classify: RR-interval rule evaluation
// Forms three signed intervals and applies the exact integer beat rules.
// ----------------------------------------------------------------------------
module rrbc_classify #(
  parameter int POS_BITS = rrbc_pkg::POSITION_BITS_DEF
) (
  input  logic [3:0][POS_BITS-1:0]         hist,
  input  rrbc_pkg::rrbc_limits_t           limits,
  output logic [rrbc_pkg::CLASS_BITS-1:0]  beat_class
);
  import rrbc_pkg::*;

  // Intervals are POS_BITS signed; the largest weighted sum needs five more
  // bits, so eight extra bits leave headroom.
  localparam int EW = POS_BITS + 8;

  localparam logic signed [EW-1:0] K2  = EW'(2);
  localparam logic signed [EW-1:0] K3  = EW'(3);
  localparam logic signed [EW-1:0] K5  = EW'(5);
  localparam logic signed [EW-1:0] K9  = EW'(9);
  localparam logic signed [EW-1:0] K19 = EW'(19);
  localparam logic signed [EW-1:0] K20 = EW'(20);
  localparam logic signed [EW-1:0] K22 = EW'(22);
  localparam logic signed [EW-1:0] K25 = EW'(25);

  logic [POS_BITS-1:0]    d1, d2, d3;
  logic signed [EW-1:0]   rr1, rr2, rr3;
  logic signed [EW-1:0]   diff21, diff23, mag21, mag23;
  logic signed [EW-1:0]   lim_diff, lim_long, lim_short;
  logic                   missing;
  logic                   c1, c2, c4, c5, c6;

  // Differences wrap modulo 2^POS_BITS and are read as two's complement.
  assign d1  = hist[1] - hist[0];
  assign d2  = hist[2] - hist[1];
  assign d3  = hist[3] - hist[2];
  assign rr1 = EW'($signed(d1));
  assign rr2 = EW'($signed(d2));
  assign rr3 = EW'($signed(d3));

  assign lim_diff  = $signed({{(EW-LIMIT_BITS){1'b0}}, limits.diff_limit});
  assign lim_long  = $signed({{(EW-LIMIT_BITS){1'b0}}, limits.long_limit});
  assign lim_short = $signed({{(EW-LIMIT_BITS){1'b0}}, limits.short_limit});

  assign diff21 = rr2 - rr1;
  assign diff23 = rr2 - rr3;
  assign mag21  = diff21[EW-1] ? -diff21 : diff21;
  assign mag23  = diff23[EW-1] ? -diff23 : diff23;

  assign missing = (hist[0] == '0) || (hist[1] == '0) ||
                   (hist[2] == '0) || (hist[3] == '0);

  // A negative interval is always below an unsigned limit, which the signed
  // compare against the zero-extended limit gives for free.
  assign c1 = (K25 * rr2 <= K22 * rr1) && (K20 * rr3 >= K19 * rr1);
  assign c2 = (rr2 + rr3) < (K2 * rr1);
  assign c4 = (mag21 < lim_diff) && (rr1 < lim_long) && (rr2 < lim_long) &&
              (K5 * rr3 > K3 * (rr1 + rr2));
  assign c5 = (mag23 < lim_diff) && (rr3 < lim_long) && (rr2 < lim_long) &&
              (K5 * rr1 > K3 * (rr3 + rr2));
  assign c6 = (rr2 < lim_short) &&
              ((K9 * rr2 < K5 * rr1) || (K9 * rr2 < K5 * rr3));

  always_comb begin
    priority if (missing) begin
      beat_class = CLASS_INSUFFICIENT;
    end else if (c4 || c5 || c6) begin
      beat_class = CLASS_VENTRICULAR;
    end else if (c1 && c2) begin
      beat_class = CLASS_ATRIAL;
    end else if (c1) begin
      beat_class = CLASS_VENTRICULAR;
    end else begin
      beat_class = CLASS_NORMAL;
    end
  end

endmodule

FILE: rtl/rr_interval_beat_classifier.sv
// ----------------------------------------------------------------------------
// rr_interval_beat_classifier: RR-interval arrhythmia beat classifier
// Keeps the last four QRS positions and classifies the middle beat of the
// three intervals they span as normal, atrial or ventricular premature.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake          | Payload
//  --------+-----------+--------------------+-----------------------------------
//  in_     | slave     | in_tvalid/tready   | tdata: position, tuser: clear flag
//  out_    | master    | out_tvalid/tready  | tdata: beat_class (zero padded)
//  cfg_    | slave     | cfg_valid/ready    | cfg_index, cfg_data (16-bit limit)
//
// Timing: one transaction is accepted per cycle while in_tready is high; its
// position is registered in the history stage, its class in the output register.
// The history register stage feeds the rule logic, which feeds the output
// register.
// Reset: rst_n is synchronous and active low. It clears the history to zero,
// empties both stages and restores the limits to 40, 150 and 120 samples.
// Both ready outputs stay low while reset is held.
// Stalls: while the output holds an untaken result, the history stage may
// still take one more transaction; after that in_tready drops until the
// output is taken. Configuration writes are accepted whenever reset is off.
//
module rr_interval_beat_classifier #(
  parameter int POSITION_BITS = rrbc_pkg::POSITION_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // Input stream.
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [rrbc_pkg::POS_IN_BITS-1:0]     in_tdata,   // [31:0] position
  input  logic                                 in_tuser,   // [0] clear_history
  // Result stream.
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [rrbc_pkg::OUT_TDATA_BITS-1:0]  out_tdata,  // [1:0] beat_class
  // Configuration write channel.
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [rrbc_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [rrbc_pkg::LIMIT_BITS-1:0]      cfg_data
);
  import rrbc_pkg::*;

  logic [3:0][POSITION_BITS-1:0] hist;
  rrbc_limits_t                  limits_r;
  logic                          s1_valid_r, s1_valid_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [CLASS_BITS-1:0]         out_class_r;
  logic [CLASS_BITS-1:0]         class_comb;
  logic                          in_accept;
  logic                          s2_load;

  // The output register takes the classified beat of stage one when it is empty or
  // its current result is being taken in the same cycle.
  assign s2_load   = s1_valid_r && (!out_valid_r || out_tready);
  // The history stage frees up when its transaction moves to the output.
  // Nothing is taken while reset is held, since the history ignores it.
  assign in_tready = rst_n && (!s1_valid_r || s2_load);
  assign in_accept = in_tvalid && in_tready;

  // The history only changes on an accepted transaction, so the rule logic
  // always sees the window that belongs to the transaction in stage one.
  rrbc_history #(
    .POS_BITS (POSITION_BITS)
  ) u_history (
    .clk           (clk),
    .rst_n         (rst_n),
    .load          (in_accept),
    .clear_history (in_tuser),
    .position      (in_tdata),
    .hist          (hist)
  );

  rrbc_classify #(
    .POS_BITS (POSITION_BITS)
  ) u_classify (
    .hist       (hist),
    .limits     (limits_r),
    .beat_class (class_comb)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_accept) begin
      s1_valid_nxt = 1'b1;
    end else if (s2_load) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s2_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load) begin
      out_class_r <= class_comb;
    end
  end

  // Limit registers; an index with no register behind it is dropped.
  assign cfg_ready = rst_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limits_r.diff_limit  <= DIFF_LIMIT_RST;
      limits_r.long_limit  <= LONG_LIMIT_RST;
      limits_r.short_limit <= SHORT_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_DIFF_LIMIT:  limits_r.diff_limit  <= cfg_data;
        REG_LONG_LIMIT:  limits_r.long_limit  <= cfg_data;
        REG_SHORT_LIMIT: limits_r.short_limit <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_BITS-CLASS_BITS){1'b0}}, out_class_r};

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for rr_interval_beat_classifier
// Streams QRS positions into the classifier and predicts every beat class in
// a scoreboard that keeps its own position history and limits. The run covers
// several limit settings, with random gaps on the input and stalls on the
// output.
// ----------------------------------------------------------------------------
module testbench;

  import rrbc_pkg::*;

  // The index that names no register. Writes to it must change nothing.
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE = 2'd3;

  // Cycles without any transaction before the run is declared hung. The worst
  // honest quiet stretch is a long sender gap next to a long output stall.
  localparam int WATCHDOG_CYCLES = 2000;

  // --------------------------------------------------------------------------
  // Scoreboard. It tracks the four most recent positions and the three limits
  // the way the block should, and queues one expected class per transaction.
  // --------------------------------------------------------------------------
  class beat_class_tracker;
    logic [POS_IN_BITS-1:0] positions [4];
    logic [LIMIT_BITS-1:0]  diff_limit;
    logic [LIMIT_BITS-1:0]  long_limit;
    logic [LIMIT_BITS-1:0]  short_limit;
    logic [CLASS_BITS-1:0]  expected_classes [$];
    int                     errors;

    function new();
      foreach (positions[i]) positions[i] = '0;
      diff_limit  = DIFF_LIMIT_RST;
      long_limit  = LONG_LIMIT_RST;
      short_limit = SHORT_LIMIT_RST;
      errors      = 0;
    endfunction

    function void set_limit(logic [CFG_IDX_BITS-1:0] index, logic [LIMIT_BITS-1:0] value);
      case (index)
        REG_DIFF_LIMIT:  diff_limit  = value;
        REG_LONG_LIMIT:  long_limit  = value;
        REG_SHORT_LIMIT: short_limit = value;
        default: ;
      endcase
    endfunction

    // Shifts one position in and predicts the class of the middle beat.
    function void take_beat(logic [POS_IN_BITS-1:0] pos, logic clr);
      logic signed [POS_IN_BITS-1:0] d0, d1, d2;
      longint rr1, rr2, rr3, dlim, llim, slim, dif12, dif23;
      bit premature, short_sum, v4, v5, v6;
      logic [CLASS_BITS-1:0] cls;
      if (clr) foreach (positions[i]) positions[i] = '0;
      for (int i = 0; i < 3; i++) positions[i] = positions[i+1];
      positions[3] = pos;
      if (positions[0] == 0 || positions[1] == 0 || positions[2] == 0 ||
          positions[3] == 0) begin
        cls = CLASS_INSUFFICIENT;
      end else begin
        // Intervals wrap modulo 2^32 and are read as signed numbers, so a
        // position that steps backwards yields a negative interval.
        d0 = positions[1] - positions[0];
        d1 = positions[2] - positions[1];
        d2 = positions[3] - positions[2];
        rr1 = d0;
        rr2 = d1;
        rr3 = d2;
        dlim = diff_limit;
        llim = long_limit;
        slim = short_limit;
        dif12 = rr2 - rr1;
        if (dif12 < 0) dif12 = -dif12;
        dif23 = rr2 - rr3;
        if (dif23 < 0) dif23 = -dif23;
        // Fractional factors are compared by exact cross-multiplication.
        premature = (25 * rr2 <= 22 * rr1) && (20 * rr3 >= 19 * rr1);
        short_sum = (rr2 + rr3 < 2 * rr1);
        v4 = dif12 < dlim && rr1 < llim && rr2 < llim && 5 * rr3 > 3 * (rr1 + rr2);
        v5 = dif23 < dlim && rr3 < llim && rr2 < llim && 5 * rr1 > 3 * (rr3 + rr2);
        v6 = rr2 < slim && (9 * rr2 < 5 * rr1 || 9 * rr2 < 5 * rr3);
        if (v4 || v5 || v6)            cls = CLASS_VENTRICULAR;
        else if (premature && short_sum) cls = CLASS_ATRIAL;
        else if (premature)            cls = CLASS_VENTRICULAR;
        else                           cls = CLASS_NORMAL;
      end
      expected_classes.push_back(cls);
    endfunction

    function void check_class(logic [OUT_TDATA_BITS-1:0] data);
      logic [CLASS_BITS-1:0] want;
      if (expected_classes.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual beat_class %0d",
                 $time, data[CLASS_BITS-1:0]);
      end else begin
        want = expected_classes.pop_front();
        if (data !== {{(OUT_TDATA_BITS-CLASS_BITS){1'b0}}, want}) begin
          errors++;
          $display("%0t: beat_class mismatch, expected %0d, actual %0d (out_tdata 0x%h)",
                   $time, want, data[CLASS_BITS-1:0], data);
        end
      end
    endfunction

    function int pending();
      return expected_classes.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and the signals around the block. Every input starts known.
  // --------------------------------------------------------------------------
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                      in_tvalid  = 1'b0;
  logic                      in_tready;
  logic [POS_IN_BITS-1:0]    in_tdata   = '0;
  logic                      in_tuser   = 1'b0;
  logic                      out_tvalid;
  logic                      out_tready = 1'b0;
  logic [OUT_TDATA_BITS-1:0] out_tdata;
  logic                      cfg_valid  = 1'b0;
  logic                      cfg_ready;
  logic [CFG_IDX_BITS-1:0]   cfg_index  = '0;
  logic [LIMIT_BITS-1:0]     cfg_data   = '0;

  beat_class_tracker tracker = new();

  // Idling switches. The main process flips them now and then so that some
  // stretches run with no gaps at all and others are heavily throttled.
  bit tx_gaps   = 1'b0;
  bit rx_stalls = 1'b0;
  int stall_left   = 0;
  int quiet_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  rr_interval_beat_classifier i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // Mostly short idle stretches, now and then a long one.
  function automatic int idle_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Output back-pressure. A stall, once started, runs to its full length.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (rx_stalls && $urandom_range(0, 3) == 0) begin
      out_tready <= 1'b0;
      stall_left <= idle_length() - 1;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Transaction monitor. Inputs are driven by nonblocking assignment, so the
  // values seen here at the edge are exactly the ones the block sampled.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) tracker.take_beat(in_tdata, in_tuser);
      if (out_tvalid && out_tready) tracker.check_class(out_tdata);
      if (cfg_valid && cfg_ready) tracker.set_limit(cfg_index, cfg_data);
    end
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  // Watchdog: a run that stops moving ends here.
  initial begin
    wait (quiet_cycles >= WATCHDOG_CYCLES);
    $display("rr_interval_beat_classifier verification failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Drivers.
  // --------------------------------------------------------------------------

  // Offers one position and holds it until the block takes it. tvalid stays
  // high into the next call unless that call opens a gap first.
  task automatic send_beat(input logic [POS_IN_BITS-1:0] pos, input logic clr);
    int gap;
    gap = (tx_gaps && $urandom_range(0, 2) == 0) ? idle_length() : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= pos;
    in_tuser  <= clr;
    do @(posedge clk); while (!in_tready);
  endtask

  // Stops sending until every outstanding class has come back.
  task automatic drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (tracker.pending() != 0);
  endtask

  // Rewrites all limits once the block is empty. The spare index is written
  // too, with junk data that must be ignored.
  task automatic apply_limits(input logic [LIMIT_BITS-1:0] dl, input logic [LIMIT_BITS-1:0] ll,
                              input logic [LIMIT_BITS-1:0] sl, input logic [LIMIT_BITS-1:0] junk);
    logic [CFG_IDX_BITS-1:0] idx [4];
    logic [LIMIT_BITS-1:0]   val [4];
    idx = '{REG_DIFF_LIMIT, REG_SPARE, REG_LONG_LIMIT, REG_SHORT_LIMIT};
    val = '{dl, junk, ll, sl};
    drain();
    // A few quiet cycles before the writes.
    repeat (4) @(posedge clk);
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
  endtask

  // Hand-picked beats: an absent first position, a steady rhythm, an atrial
  // premature beat, a premature beat with a long sum, a very short middle
  // interval, a clear on a live position, wrap past the top of the position
  // range, a backwards step, half-range jumps and a missing beat mid-stream.
  task automatic send_directed();
    logic [POS_IN_BITS-1:0] pos [24];
    logic                   clr [24];
    pos = '{32'd0, 32'd1000, 32'd1100, 32'd1200, 32'd1300, 32'd1380, 32'd1480, 32'd1560,
            32'd1690, 32'd1890, 32'd1990, 32'd2190, 32'hFFFF_FF00, 32'hFFFF_FFFF,
            32'h0000_0010, 32'h0000_0090, 32'h0000_0040, 32'h8000_0001, 32'h0000_0001,
            32'h8000_0001, 32'h7FFF_FFFF, 32'd0, 32'hAAAA_AAAA, 32'h5555_5555};
    clr = '{1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
            1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0};
    for (int i = 0; i < 24; i++) send_beat(pos[i], clr[i]);
  endtask

  // A run of beats around a base interval, with jitter, premature and late
  // beats and the odd backwards step. Large bases matter once the limits
  // are opened up.
  task automatic send_rhythm(input int beats);
    int base, rr, kind;
    bit clear_first;
    logic [POS_IN_BITS-1:0] pos;
    base = ($urandom_range(0, 3) != 0) ? $urandom_range(20, 250) : $urandom_range(250, 80000);
    pos = ($urandom_range(0, 4) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 4 * base) : $urandom;
    clear_first = 1'($urandom_range(0, 1));
    for (int n = 0; n < beats; n++) begin
      kind = $urandom_range(0, 9);
      if (kind < 6)      rr = base - base / 16 + int'($urandom_range(0, base / 8));
      else if (kind < 8) rr = base * int'($urandom_range(40, 95)) / 100;
      else if (kind < 9) rr = base * int'($urandom_range(105, 220)) / 100;
      else               rr = 0 - int'($urandom_range(1, base));
      pos = pos + rr;
      send_beat(pos, clear_first && n == 0);
    end
  endtask

  // Random traffic: mostly rhythm runs, some noise and missing beats, and
  // occasional pauses that let the pipeline empty completely.
  task automatic run_random(input int count);
    int sent, pick, n;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
        n = $urandom_range(4, 10);
        send_rhythm(n);
        sent += n;
      end else if (pick < 88) begin
        send_beat($urandom, 1'($urandom_range(0, 1)));
        sent++;
      end else if (pick < 94) begin
        send_beat('0, 1'($urandom_range(0, 1)));
        sent++;
      end else if (pick < 96) begin
        drain();
      end else begin
        tx_gaps   = $urandom_range(0, 2) != 0;
        rx_stalls = $urandom_range(0, 2) != 0;
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence: reset, directed beats and random traffic at the reset limits,
  // then random traffic under closed, fully open, random and restored limits.
  // --------------------------------------------------------------------------
  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    send_directed();
    tx_gaps   = 1'b1;
    rx_stalls = 1'b1;
    run_random(226);

    apply_limits('0, '0, '0, 16'hFFFF);
    run_random(220);

    apply_limits(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000);
    run_random(220);

    apply_limits(LIMIT_BITS'($urandom_range(0, 65535)), LIMIT_BITS'($urandom_range(0, 65535)),
                 LIMIT_BITS'($urandom_range(0, 65535)), LIMIT_BITS'($urandom_range(0, 65535)));
    run_random(220);

    apply_limits(DIFF_LIMIT_RST, LONG_LIMIT_RST, SHORT_LIMIT_RST,
                 LIMIT_BITS'($urandom_range(0, 65535)));
    run_random(210);

    drain();
    repeat (10) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("rr_interval_beat_classifier verification clean");
    end else begin
      $display("rr_interval_beat_classifier verification failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/rrbc_pkg.sv
rtl/rrbc_history.sv
rtl/rrbc_classify.sv
rtl/rr_interval_beat_classifier.sv
tb/testbench.sv
